// ----- rtl/core/dsgd_pkg.sv -----
package dsgd_pkg;

    // Default sizes of the stores
    localparam int IN_MAX_DEF    = 64;
    localparam int OUT_MAX_DEF   = 64;
    localparam int BATCH_MAX_DEF = 64;

    // Stream payload widths
    localparam int S_TDATA_W = 56;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 40;

    // Configuration port
    localparam int CFG_AW = 2;
    localparam int CFG_DW = 16;

    localparam logic [CFG_AW-1:0] CFG_IN_SIZE    = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_OUT_SIZE   = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_LEARN_RATE = 2'd2;
    localparam logic [CFG_AW-1:0] CFG_PROP_BACK  = 2'd3;

    localparam logic [6:0]  IN_SIZE_RST    = 7'd64;
    localparam logic [6:0]  OUT_SIZE_RST   = 7'd64;
    localparam logic [15:0] LEARN_RATE_RST = 16'd655;

    // Item opcodes
    typedef enum logic [1:0] {
        OP_WEIGHT = 2'd0,
        OP_BIAS   = 2'd1,
        OP_FWD    = 2'd2,
        OP_GRAD   = 2'd3
    } op_t;

    // Result kinds
    localparam logic KIND_FWD  = 1'b0;
    localparam logic KIND_GRAD = 1'b1;

    // Clamp a 49-bit sum to the 48-bit accumulator range
    function automatic logic signed [47:0] sat48(input logic signed [48:0] v);
        logic signed [47:0] r;
        if (v[48] != v[47]) begin
            r = v[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
        end else begin
            r = v[47:0];
        end
        return r;
    endfunction

    // Clamp a 50-bit value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
        logic signed [31:0] r;
        if (v > 50'sh0_0000_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -50'sh0_0000_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/dense_layer_sgd_core.sv -----
// Fully connected layer with batch SGD training, signed Q16.16 data.
// Input channel s_*: one item per handshake. s_tuser holds the opcode
// (write weight, write bias, forward element, gradient element) and the
// end-of-batch flag, s_tlast marks the last element of a sample row.
// Result channel m_*: one output element per handshake, m_tuser is the
// kind (forward output or back-propagated gradient), m_tlast ends a row.
// Configuration: cfg_wr_en writes cfg_wr_data into register cfg_addr
// (in_size, out_size, learn_rate, propagate_back). The user must write
// only while the block is idle; the block itself does not enforce it.
// A forward or gradient element runs one multiply-accumulate per cycle
// through the memories for each of the n neurons (forward) or features
// (gradient) in use. A row end then emits one element per index below n
// (gradients only with propagate_back set); a stalled receiver holds the
// output register and the block waits. A gradient batch end sweeps all
// IN_MAX*OUT_MAX weights and OUT_MAX biases: an entry in use divides
// its update by the batch length bit-serially, an unused one skips it.
// After reset a clearing pass zeroes the gradient sums and accumulators;
// s_tready stays low until it ends.
module dense_layer_sgd_core #(
    parameter int IN_MAX    = dsgd_pkg::IN_MAX_DEF,
    parameter int OUT_MAX   = dsgd_pkg::OUT_MAX_DEF,
    parameter int BATCH_MAX = dsgd_pkg::BATCH_MAX_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // sample[5:0], in_index[11:6], out_index[17:12], value[49:18], zero fill
    input  logic [dsgd_pkg::S_TDATA_W-1:0] s_tdata,
    // op[1:0], end_of_batch[2]
    input  logic [dsgd_pkg::S_TUSER_W-1:0] s_tuser,
    input  logic                           s_tlast,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // index[5:0], value_res[37:6], zero fill
    output logic [dsgd_pkg::M_TDATA_W-1:0] m_tdata,
    // kind[0]
    output logic [0:0]                     m_tuser,
    output logic                           m_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic                           cfg_wr_en,
    input  logic [dsgd_pkg::CFG_AW-1:0]    cfg_addr,
    input  logic [dsgd_pkg::CFG_DW-1:0]    cfg_wr_data
);
    import dsgd_pkg::*;

    localparam int W_DEPTH   = IN_MAX * OUT_MAX;
    localparam int X_DEPTH   = BATCH_MAX * IN_MAX;
    localparam int ACC_DEPTH = (IN_MAX > OUT_MAX) ? IN_MAX : OUT_MAX;
    localparam int W_AW      = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1;
    localparam int X_AW      = (X_DEPTH > 1) ? $clog2(X_DEPTH) : 1;
    localparam int B_AW      = (OUT_MAX > 1) ? $clog2(OUT_MAX) : 1;
    localparam int A_AW      = (ACC_DEPTH > 1) ? $clog2(ACC_DEPTH) : 1;
    localparam int CW        = $clog2(ACC_DEPTH + 1);
    localparam int UIW       = (IN_MAX > 1) ? $clog2(IN_MAX) : 1;
    localparam int UJW       = (OUT_MAX > 1) ? $clog2(OUT_MAX) : 1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MAC,
        ST_MAC_DRAIN,
        ST_EMIT_RD,
        ST_EMIT_DATA,
        ST_EMIT_HOLD,
        ST_UPD_RD,
        ST_UPD_MUL,
        ST_UPD_PREP,
        ST_UPD_DIV,
        ST_UPD_WR
    } state_t;

    state_t state_reg;

    // Configuration registers
    logic [6:0]  in_size_reg;
    logic [6:0]  out_size_reg;
    logic [15:0] learn_rate_reg;
    logic        prop_back_reg;
    logic [6:0]  batch_rows_reg;

    // Latched item
    op_t                op_reg;
    logic [5:0]         samp_reg;
    logic [5:0]         ii_reg;
    logic [5:0]         oi_reg;
    logic signed [31:0] val_reg;
    logic               eor_reg;
    logic               eob_reg;
    logic [CW-1:0]      n_reg;
    logic [CW-1:0]      k_reg;
    logic [W_AW-1:0]    clr_reg;

    // Multiply-accumulate pipeline
    logic               p1_valid_reg;
    logic [CW-1:0]      p1_k_reg;
    logic               p1_first_reg;
    logic               p2_valid_reg;
    logic [CW-1:0]      p2_k_reg;
    logic               p2_first_reg;
    logic signed [63:0] prod_reg;
    logic signed [63:0] prodx_reg;
    logic signed [47:0] acc_q_reg;
    logic signed [47:0] wg_q_reg;
    logic signed [47:0] bg_q_reg;

    // Update sweep
    logic [UIW-1:0]     ui_reg;
    logic [UJW-1:0]     uj_reg;
    logic [W_AW-1:0]    ua_reg;
    logic               ubias_reg;
    logic               uuse_reg;
    logic signed [64:0] uprod_reg;
    logic signed [31:0] wold_reg;
    logic               uneg_reg;
    logic [47:0]        udiv_reg;
    logic [6:0]         urem_reg;
    logic [5:0]         ucnt_reg;

    // Output register
    logic               m_valid_reg;
    logic [5:0]         m_index_reg;
    logic signed [31:0] m_value_reg;
    logic               m_kind_reg;
    logic               m_last_reg;

    // Memory ports
    logic               w_we, b_we, x_we, acc_we, wg_we, bg_we;
    logic [W_AW-1:0]    w_waddr, w_raddr, wg_waddr, wg_raddr;
    logic [B_AW-1:0]    b_waddr, b_raddr, bg_waddr, bg_raddr;
    logic [X_AW-1:0]    x_waddr, x_raddr;
    logic [A_AW-1:0]    acc_waddr, acc_raddr;
    logic [31:0]        w_wdata, b_wdata, x_wdata;
    logic [47:0]        acc_wdata, wg_wdata, bg_wdata;
    logic signed [31:0] w_rd, b_rd, x_rd;
    logic signed [47:0] acc_rd, wg_rd, bg_rd;

    // Decoded input fields
    op_t                in_op;
    logic [5:0]         in_samp, in_ii, in_oi;
    logic signed [31:0] in_val;
    logic               in_eob;
    logic               s_acc;

    logic [CW-1:0]      ni, no;
    logic [6:0]         rows;
    logic               is_grad;
    logic               fwd_active, grad_active;
    logic               emit_out;

    logic signed [47:0] div_mag;
    logic signed [48:0] div_d0;
    logic [7:0]         div_trial;
    logic signed [49:0] upd_q;
    logic signed [31:0] upd_new;
    logic signed [31:0] emit_val;
    logic signed [64:0] upd_prod;

    assign in_op   = op_t'(s_tuser[1:0]);
    assign in_eob  = s_tuser[2];
    assign in_samp = s_tdata[5:0];
    assign in_ii   = s_tdata[11:6];
    assign in_oi   = s_tdata[17:12];
    assign in_val  = s_tdata[49:18];

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;

    // Effective sizes: zero acts as one, clamp to the store size
    assign ni = CW'((in_size_reg == 7'd0) ? 1 :
                    ((int'(in_size_reg) > IN_MAX) ? IN_MAX : int'(in_size_reg)));
    assign no = CW'((out_size_reg == 7'd0) ? 1 :
                    ((int'(out_size_reg) > OUT_MAX) ? OUT_MAX : int'(out_size_reg)));
    assign rows = (batch_rows_reg == 7'd0) ? 7'd1 : batch_rows_reg;

    assign is_grad     = (op_reg == OP_GRAD);
    assign fwd_active  = (int'(in_ii) < int'(ni)) && (int'(in_samp) < BATCH_MAX);
    assign grad_active = (int'(in_oi) < int'(no)) && (int'(in_samp) < BATCH_MAX);
    assign emit_out    = !is_grad || prop_back_reg;

    // Update arithmetic
    assign upd_prod  = $signed({1'b0, learn_rate_reg}) * (ubias_reg ? bg_rd : wg_rd);
    assign div_d0    = uprod_reg[64:16];
    assign div_mag   = div_d0[48] ? 48'(-div_d0) : div_d0[47:0];
    assign div_trial = {urem_reg, udiv_reg[47]};
    assign upd_q     = uneg_reg ? -$signed({2'b00, udiv_reg}) : $signed({2'b00, udiv_reg});
    assign upd_new   = sat32($signed({{18{wold_reg[31]}}, wold_reg}) - upd_q);

    // Emitted value: forward adds the bias
    assign emit_val = is_grad ? sat32($signed({{2{acc_rd[47]}}, acc_rd})) :
                      sat32($signed({{2{acc_rd[47]}}, acc_rd}) +
                            $signed({{18{b_rd[31]}}, b_rd}));

    // Drive memory ports
    always_comb begin
        w_we = 1'b0;   w_waddr = '0;   w_wdata = '0;   w_raddr = '0;
        b_we = 1'b0;   b_waddr = '0;   b_wdata = '0;   b_raddr = '0;
        x_we = 1'b0;   x_waddr = '0;   x_wdata = '0;   x_raddr = '0;
        acc_we = 1'b0; acc_waddr = '0; acc_wdata = '0; acc_raddr = '0;
        wg_we = 1'b0;  wg_waddr = '0;  wg_wdata = '0;  wg_raddr = '0;
        bg_we = 1'b0;  bg_waddr = '0;  bg_wdata = '0;  bg_raddr = '0;
        case (state_reg)
            ST_CLEAR: begin
                wg_we     = 1'b1;
                wg_waddr  = clr_reg;
                acc_we    = (int'(clr_reg) < ACC_DEPTH);
                acc_waddr = clr_reg[A_AW-1:0];
                bg_we     = (int'(clr_reg) < OUT_MAX);
                bg_waddr  = clr_reg[B_AW-1:0];
            end
            ST_IDLE: begin
                if (s_acc) begin
                    case (in_op)
                        OP_WEIGHT: begin
                            w_we    = (int'(in_ii) < IN_MAX) && (int'(in_oi) < OUT_MAX);
                            w_waddr = W_AW'(int'(in_ii) * OUT_MAX + int'(in_oi));
                            w_wdata = in_val;
                        end
                        OP_BIAS: begin
                            b_we    = (int'(in_oi) < OUT_MAX);
                            b_waddr = B_AW'(in_oi);
                            b_wdata = in_val;
                        end
                        OP_FWD: begin
                            x_we    = fwd_active;
                            x_waddr = X_AW'(int'(in_samp) * IN_MAX + int'(in_ii));
                            x_wdata = in_val;
                        end
                        default: ;
                    endcase
                end
            end
            ST_MAC: begin
                w_raddr   = is_grad ? W_AW'(int'(k_reg) * OUT_MAX + int'(oi_reg)) :
                                      W_AW'(int'(ii_reg) * OUT_MAX + int'(k_reg));
                acc_raddr = k_reg[A_AW-1:0];
                x_raddr   = X_AW'(int'(samp_reg) * IN_MAX + int'(k_reg));
                wg_raddr  = W_AW'(int'(k_reg) * OUT_MAX + int'(oi_reg));
                bg_raddr  = B_AW'(oi_reg);
            end
            ST_EMIT_RD: begin
                acc_raddr = k_reg[A_AW-1:0];
                b_raddr   = B_AW'(k_reg);
            end
            ST_EMIT_DATA: begin
                acc_we    = 1'b1;
                acc_waddr = k_reg[A_AW-1:0];
            end
            ST_UPD_RD: begin
                w_raddr  = ua_reg;
                wg_raddr = ua_reg;
                b_raddr  = B_AW'(uj_reg);
                bg_raddr = B_AW'(uj_reg);
            end
            ST_UPD_WR: begin
                if (ubias_reg) begin
                    b_we     = uuse_reg;
                    b_waddr  = B_AW'(uj_reg);
                    b_wdata  = upd_new;
                    bg_we    = 1'b1;
                    bg_waddr = B_AW'(uj_reg);
                end else begin
                    w_we     = uuse_reg;
                    w_waddr  = ua_reg;
                    w_wdata  = upd_new;
                    wg_we    = 1'b1;
                    wg_waddr = ua_reg;
                end
            end
            default: ;
        endcase
        // Write back the accumulate stage
        if (p2_valid_reg) begin
            acc_we    = !is_grad || prop_back_reg;
            acc_waddr = p2_k_reg[A_AW-1:0];
            acc_wdata = sat48($signed({acc_q_reg[47], acc_q_reg}) +
                              $signed({prod_reg[63], prod_reg[63:16]}));
            wg_we     = is_grad;
            wg_waddr  = W_AW'(int'(p2_k_reg) * OUT_MAX + int'(oi_reg));
            wg_wdata  = sat48($signed({wg_q_reg[47], wg_q_reg}) +
                              $signed({prodx_reg[63], prodx_reg[63:16]}));
            bg_we     = is_grad && p2_first_reg;
            bg_waddr  = B_AW'(oi_reg);
            bg_wdata  = sat48($signed({bg_q_reg[47], bg_q_reg}) +
                              $signed({{17{val_reg[31]}}, val_reg}));
        end
    end

    dsgd_ram #(.WIDTH(32), .DEPTH(W_DEPTH)) u_w_ram (
        .aclk(aclk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
        .raddr(w_raddr), .rdata(w_rd)
    );
    dsgd_ram #(.WIDTH(32), .DEPTH(OUT_MAX)) u_b_ram (
        .aclk(aclk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
        .raddr(b_raddr), .rdata(b_rd)
    );
    dsgd_ram #(.WIDTH(32), .DEPTH(X_DEPTH)) u_x_ram (
        .aclk(aclk), .we(x_we), .waddr(x_waddr), .wdata(x_wdata),
        .raddr(x_raddr), .rdata(x_rd)
    );
    dsgd_ram #(.WIDTH(48), .DEPTH(ACC_DEPTH)) u_acc_ram (
        .aclk(aclk), .we(acc_we), .waddr(acc_waddr), .wdata(acc_wdata),
        .raddr(acc_raddr), .rdata(acc_rd)
    );
    dsgd_ram #(.WIDTH(48), .DEPTH(W_DEPTH)) u_wg_ram (
        .aclk(aclk), .we(wg_we), .waddr(wg_waddr), .wdata(wg_wdata),
        .raddr(wg_raddr), .rdata(wg_rd)
    );
    dsgd_ram #(.WIDTH(48), .DEPTH(OUT_MAX)) u_bg_ram (
        .aclk(aclk), .we(bg_we), .waddr(bg_waddr), .wdata(bg_wdata),
        .raddr(bg_raddr), .rdata(bg_rd)
    );

    // Sequencer, pipeline and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            in_size_reg    <= IN_SIZE_RST;
            out_size_reg   <= OUT_SIZE_RST;
            learn_rate_reg <= LEARN_RATE_RST;
            prop_back_reg  <= 1'b1;
            batch_rows_reg <= '0;
            clr_reg        <= '0;
            k_reg          <= '0;
            p1_valid_reg   <= 1'b0;
            p2_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            // Configuration writes
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_IN_SIZE:    in_size_reg    <= cfg_wr_data[6:0];
                    CFG_OUT_SIZE:   out_size_reg   <= cfg_wr_data[6:0];
                    CFG_LEARN_RATE: learn_rate_reg <= cfg_wr_data;
                    CFG_PROP_BACK:  prop_back_reg  <= cfg_wr_data[0];
                    default: ;
                endcase
            end

            // Advance the accumulate pipeline
            p1_valid_reg <= (state_reg == ST_MAC);
            p1_k_reg     <= k_reg;
            p1_first_reg <= (k_reg == '0);
            p2_valid_reg <= p1_valid_reg;
            p2_k_reg     <= p1_k_reg;
            p2_first_reg <= p1_first_reg;
            prod_reg     <= val_reg * w_rd;
            prodx_reg    <= val_reg * x_rd;
            acc_q_reg    <= acc_rd;
            wg_q_reg     <= wg_rd;
            bg_q_reg     <= bg_rd;

            case (state_reg)
                ST_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == W_AW'(W_DEPTH - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_acc) begin
                        op_reg   <= in_op;
                        samp_reg <= in_samp;
                        ii_reg   <= in_ii;
                        oi_reg   <= in_oi;
                        val_reg  <= in_val;
                        eor_reg  <= s_tlast;
                        eob_reg  <= in_eob;
                        k_reg    <= '0;
                        case (in_op)
                            OP_FWD: begin
                                n_reg <= no;
                                if (s_tlast && in_eob) begin
                                    batch_rows_reg <= 7'(in_samp) + 7'd1;
                                end
                                if (fwd_active) begin
                                    state_reg <= ST_MAC;
                                end else if (s_tlast) begin
                                    state_reg <= ST_EMIT_RD;
                                end
                            end
                            OP_GRAD: begin
                                n_reg <= ni;
                                if (grad_active) begin
                                    state_reg <= ST_MAC;
                                end else if (s_tlast) begin
                                    state_reg <= ST_EMIT_RD;
                                end else if (in_eob) begin
                                    ui_reg    <= '0;
                                    uj_reg    <= '0;
                                    ua_reg    <= '0;
                                    ubias_reg <= 1'b0;
                                    state_reg <= ST_UPD_RD;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_MAC: begin
                    if (k_reg == n_reg - 1'b1) begin
                        state_reg <= ST_MAC_DRAIN;
                    end else begin
                        k_reg <= k_reg + 1'b1;
                    end
                end
                ST_MAC_DRAIN: begin
                    if (!p1_valid_reg && !p2_valid_reg) begin
                        k_reg <= '0;
                        if (eor_reg) begin
                            state_reg <= ST_EMIT_RD;
                        end else if (is_grad && eob_reg) begin
                            ui_reg    <= '0;
                            uj_reg    <= '0;
                            ua_reg    <= '0;
                            ubias_reg <= 1'b0;
                            state_reg <= ST_UPD_RD;
                        end else begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                ST_EMIT_RD: begin
                    state_reg <= ST_EMIT_DATA;
                end
                ST_EMIT_DATA, ST_EMIT_HOLD: begin
                    if (state_reg == ST_EMIT_DATA && emit_out) begin
                        // Load the output register and wait for the receiver
                        m_valid_reg <= 1'b1;
                        m_index_reg <= 6'(k_reg);
                        m_value_reg <= emit_val;
                        m_kind_reg  <= is_grad ? KIND_GRAD : KIND_FWD;
                        m_last_reg  <= (k_reg == n_reg - 1'b1);
                        state_reg   <= ST_EMIT_HOLD;
                    end else if (state_reg == ST_EMIT_HOLD && !m_tready) begin
                        state_reg <= ST_EMIT_HOLD;
                    end else begin
                        m_valid_reg <= 1'b0;
                        if (k_reg == n_reg - 1'b1) begin
                            if (is_grad && eob_reg) begin
                                ui_reg    <= '0;
                                uj_reg    <= '0;
                                ua_reg    <= '0;
                                ubias_reg <= 1'b0;
                                state_reg <= ST_UPD_RD;
                            end else begin
                                state_reg <= ST_IDLE;
                            end
                        end else begin
                            k_reg     <= k_reg + 1'b1;
                            state_reg <= ST_EMIT_RD;
                        end
                    end
                end
                ST_UPD_RD: begin
                    uuse_reg  <= (int'(uj_reg) < int'(no)) &&
                                 (ubias_reg || (int'(ui_reg) < int'(ni)));
                    state_reg <= ST_UPD_MUL;
                end
                ST_UPD_MUL: begin
                    uprod_reg <= upd_prod;
                    wold_reg  <= ubias_reg ? b_rd : w_rd;
                    state_reg <= uuse_reg ? ST_UPD_PREP : ST_UPD_WR;
                end
                ST_UPD_PREP: begin
                    uneg_reg  <= div_d0[48];
                    udiv_reg  <= div_mag;
                    urem_reg  <= '0;
                    ucnt_reg  <= '0;
                    state_reg <= ST_UPD_DIV;
                end
                ST_UPD_DIV: begin
                    // One quotient bit per cycle
                    if (div_trial >= {1'b0, rows}) begin
                        urem_reg <= 7'(div_trial - {1'b0, rows});
                        udiv_reg <= {udiv_reg[46:0], 1'b1};
                    end else begin
                        urem_reg <= div_trial[6:0];
                        udiv_reg <= {udiv_reg[46:0], 1'b0};
                    end
                    ucnt_reg <= ucnt_reg + 1'b1;
                    if (ucnt_reg == 6'd47) begin
                        state_reg <= ST_UPD_WR;
                    end
                end
                ST_UPD_WR: begin
                    if (!ubias_reg) begin
                        ua_reg <= ua_reg + 1'b1;
                    end
                    if (uj_reg == UJW'(OUT_MAX - 1)) begin
                        uj_reg <= '0;
                        if (ubias_reg) begin
                            batch_rows_reg <= '0;
                            state_reg      <= ST_IDLE;
                        end else begin
                            state_reg <= ST_UPD_RD;
                            if (ui_reg == UIW'(IN_MAX - 1)) begin
                                ubias_reg <= 1'b1;
                            end else begin
                                ui_reg <= ui_reg + 1'b1;
                            end
                        end
                    end else begin
                        uj_reg    <= uj_reg + 1'b1;
                        state_reg <= ST_UPD_RD;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_value_reg, m_index_reg};
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

endmodule

// ----- rtl/core/dsgd_ram.sv -----
module dsgd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                     aclk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one entry, read one entry with registered data
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/dsgd_checker.sv -----
module dsgd_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [dsgd_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                           m_tlast,
    input logic                           m_tvalid,
    input logic                           m_tready
);
    import dsgd_pkg::*;

    // Results go out only while no item is being taken
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input taken while a result is pending");

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // Reset starts the clearing pass with both channels quiet
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !s_tready && !m_tvalid)
        else $error("channel active right after reset");

    // No result appears in the cycle after an item is taken
    a_no_instant: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !m_tvalid)
        else $error("result appeared too early");

endmodule

bind dense_layer_sgd_core dsgd_checker u_dsgd_checker (.*);
